>>> hdl/akd_pkg.sv
// package for the autokey table stream decryptor
// holds command codes, controller states, table geometry and mixing constants
// no dependencies
`default_nettype none

package akd_pkg;

    localparam int unsigned TABLE_DEPTH = 256;
    localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);

    localparam logic [31:0] SEED_MASK = 32'h5555_5555;
    localparam logic [31:0] MIX_MULT  = 32'd39916801;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_WORD  = 2'd1,
        CMD_BYTE  = 2'd2,
        CMD_PLAIN = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FILL,
        ST_READ
    } t_state;

    typedef struct packed {
        logic              we;
        logic              last;
        logic [ADDR_W-1:0] addr;
        logic [31:0]       wdata;
    } t_fill_req;

endpackage

`default_nettype wire

>>> hdl/akd_table.sv
// single-port mixing table, read data registered and shown in the cycle after the address
// depends on akd_pkg
`default_nettype none

module akd_table (
    input  wire logic                      i_clk,
    input  wire logic                      i_we,
    input  wire logic [akd_pkg::ADDR_W-1:0] i_addr,
    input  wire logic [31:0]               i_wdata,
    output logic      [31:0]               o_rdata
);
    import akd_pkg::*;

    logic [31:0] r_mem [TABLE_DEPTH];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> hdl/akd_fill.sv
// table fill sequencer: rotate right by one and multiply, one entry per cycle
// depends on akd_pkg
`default_nettype none

module akd_fill (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [31:0]        i_seed,
    output akd_pkg::t_fill_req      o_req
);
    import akd_pkg::*;

    logic              r_busy;
    logic              n_busy;
    logic [ADDR_W-1:0] r_cnt;
    logic [ADDR_W-1:0] n_cnt;
    logic [31:0]       r_k;
    logic [31:0]       n_k;
    logic [31:0]       w_rot;
    logic [31:0]       w_prod;
    logic              w_last;

    assign w_rot  = {r_k[0], r_k[31:1]};
    assign w_prod = w_rot * MIX_MULT;
    assign w_last = r_busy && (r_cnt == ADDR_W'(TABLE_DEPTH - 1));

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_k    = r_k;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_k    = i_seed;
        end else if (r_busy) begin
            n_cnt = r_cnt + ADDR_W'(1);
            n_k   = w_prod;
            if (w_last) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_k <= n_k;
    end

    assign o_req.we    = r_busy;
    assign o_req.last  = w_last;
    assign o_req.addr  = r_cnt;
    assign o_req.wdata = w_prod;

endmodule

`default_nettype wire

>>> hdl/autokey_table_stream_decryptor_top.sv
// top level of the autokey table stream decryptor
// depends on akd_pkg, akd_table and akd_fill
//
// A load beat (tuser 0) sets the key from the seed and refills the 256-word
// mixing table, one entry per cycle, holding off input until the fill is done
// and giving no result. A word beat with key update (tuser 1) holds off input
// while the four cipher bytes are looked up one after another through the
// single table port. Byte beats (tuser 2) and plain word beats (tuser 3) leave
// the controller idle. Results leave through an output register backed by one
// spare entry, so input keeps flowing while one result waits to be taken.
`default_nettype none

module autokey_table_stream_decryptor_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [31:0] i_s_tdata,   // data
    input  wire logic [1:0]  i_s_tuser,   // cmd
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic      [31:0] o_m_tdata    // plain
);
    import akd_pkg::*;

    t_state            r_state;
    t_state            n_state;
    t_cmd              w_cmd;
    logic              w_acc;
    logic              w_ready;
    logic [31:0]       r_key;
    logic [31:0]       n_key;
    logic [31:0]       w_key_now;
    logic [31:0]       r_data;
    logic [1:0]        r_idx;
    logic [1:0]        n_idx;
    logic              r_rvld;
    logic              w_rd;
    logic              w_we;
    logic [ADDR_W-1:0] w_addr;
    logic [31:0]       w_rdata;
    logic [31:0]       w_res;
    logic              w_has_res;
    logic              w_out_free;
    logic              r_ovld;
    logic [31:0]       r_odata;
    logic              r_pvld;
    logic [31:0]       r_pdata;
    logic              w_start;
    t_fill_req         w_fill;

    assign w_cmd = t_cmd'(i_s_tuser);
    assign w_acc = i_s_tvalid && w_ready;

    akd_fill u_fill (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_seed  (i_s_tdata ^ SEED_MASK),
        .o_req   (w_fill)
    );

    akd_table u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (w_addr),
        .i_wdata (w_fill.wdata),
        .o_rdata (w_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_acc && w_cmd == CMD_LOAD) begin
                    n_state = ST_FILL;
                end else if (w_acc && w_cmd == CMD_WORD) begin
                    n_state = ST_READ;
                end
            end
            ST_FILL: begin
                if (w_fill.last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_READ: begin
                if (r_idx == 2'd3) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs of the controller
    always_comb begin
        w_ready = 1'b0;
        w_start = 1'b0;
        w_we    = 1'b0;
        w_rd    = 1'b0;
        w_addr  = w_fill.addr;
        n_idx   = r_idx;
        unique case (r_state)
            ST_IDLE: begin
                w_ready = !r_pvld;
                if (w_acc) begin
                    unique case (w_cmd)
                        CMD_LOAD: w_start = 1'b1;
                        CMD_WORD: begin
                            w_rd   = 1'b1;
                            w_addr = i_s_tdata[7:0];
                            n_idx  = 2'd1;
                        end
                        CMD_BYTE: begin
                            w_rd   = 1'b1;
                            w_addr = i_s_tdata[7:0];
                        end
                        CMD_PLAIN: w_rd = 1'b0;
                        default:   w_rd = 1'b0;
                    endcase
                end
            end
            ST_FILL: begin
                w_we = w_fill.we;
            end
            ST_READ: begin
                w_rd   = 1'b1;
                w_addr = r_data[r_idx*8 +: 8];
                n_idx  = r_idx + 2'd1;
            end
            default: w_ready = 1'b0;
        endcase
    end

    // key with the entry returning this cycle folded in
    assign w_key_now = r_key ^ (r_rvld ? w_rdata : 32'd0);

    always_comb begin
        n_key = w_key_now;
        if (w_acc && w_cmd == CMD_LOAD) begin
            n_key = i_s_tdata ^ SEED_MASK;
        end
    end

    assign w_has_res = (w_cmd != CMD_LOAD);
    assign w_res     = (w_cmd == CMD_BYTE)
                     ? {24'd0, i_s_tdata[7:0] ^ w_key_now[7:0]}
                     : (i_s_tdata ^ w_key_now);

    assign w_out_free = !r_ovld || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_key   <= '0;
            r_idx   <= '0;
            r_rvld  <= 1'b0;
            r_ovld  <= 1'b0;
            r_pvld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_key   <= n_key;
            r_idx   <= n_idx;
            r_rvld  <= w_rd;
            if (w_out_free) begin
                if (r_pvld) begin
                    r_ovld <= 1'b1;
                    r_pvld <= 1'b0;
                end else begin
                    r_ovld <= w_acc && w_has_res;
                end
            end else if (w_acc && w_has_res) begin
                r_pvld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_data <= i_s_tdata;
        end
        if (w_out_free) begin
            r_odata <= r_pvld ? r_pdata : w_res;
        end else if (w_acc && w_has_res) begin
            r_pdata <= w_res;
        end
    end

    assign o_s_tready = w_ready;
    assign o_m_tvalid = r_ovld;
    assign o_m_tdata  = r_odata;

endmodule

`default_nettype wire

>>> hdl/akd_checker.sv
// port-level checks for the autokey table stream decryptor
// depends on akd_pkg, bound to autokey_table_stream_decryptor_top
`default_nettype none

module akd_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_tvalid,
    input wire logic        o_s_tready,
    input wire logic [1:0]  i_s_tuser,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [31:0] o_m_tdata
);
    import akd_pkg::*;

    logic w_in_beat;

    assign w_in_beat = i_s_tvalid && o_s_tready;

    a_rst_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled output beat changed");

    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_beat && i_s_tuser == CMD_LOAD |=> !o_s_tready)
        else $error("input ready during table fill");

    a_word_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_beat && i_s_tuser == CMD_WORD |=> !o_s_tready ##1 !o_s_tready ##1 !o_s_tready)
        else $error("input ready during word lookups");

endmodule

bind autokey_table_stream_decryptor_top akd_checker u_akd_checker (.*);

`default_nettype wire

>>> sim/autokey_table_stream_decryptor_top_tb.sv
// testbench for autokey_table_stream_decryptor_top: directed and random beats
// checked against an in-bench key and mixing table tracker; depends on akd_pkg
`timescale 1ns / 100ps

module autokey_table_stream_decryptor_top_tb;
    import akd_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned DRAIN_CYCLES = 300;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = CMD_LOAD;
    logic        m_tready = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [31:0] o_m_tdata;

    logic [31:0] key_track;
    logic [31:0] mix_table_track [TABLE_DEPTH];
    logic [31:0] expected_plain_q [$];

    int unsigned src_idle_pct = 0;
    int unsigned sink_idle_pct = 0;
    int unsigned err_count = 0;
    int unsigned cycle_count = 0;

    autokey_table_stream_decryptor_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),   // data
        .i_s_tuser  (s_tuser),   // cmd
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata)  // plain
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] exp_val,
                                   input logic [31:0] got_val);
        $display("mismatch at cycle %0d: %s expected %08h got %08h",
                 cycle_count, what, exp_val, got_val);
        err_count++;
    endtask

    // key and table update for one accepted beat, pushes the expected plain word for every beat but a load
    task automatic track_decrypt_state(input t_cmd cmd, input logic [31:0] data);
        logic [31:0] k;
        case (cmd)
            CMD_LOAD: begin
                k = data ^ SEED_MASK;
                key_track = k;
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                    k = {k[0], k[31:1]};
                    k = k * MIX_MULT;
                    mix_table_track[i] = k;
                end
            end
            CMD_WORD: begin
                expected_plain_q.push_back(data ^ key_track);
                key_track = key_track ^ mix_table_track[data[7:0]]
                          ^ mix_table_track[data[15:8]]
                          ^ mix_table_track[data[23:16]]
                          ^ mix_table_track[data[31:24]];
            end
            CMD_BYTE: begin
                expected_plain_q.push_back({24'h0, data[7:0] ^ key_track[7:0]});
                key_track = key_track ^ mix_table_track[data[7:0]];
            end
            default: begin
                expected_plain_q.push_back(data ^ key_track);
            end
        endcase
    endtask

    task automatic send_beat(input t_cmd cmd, input logic [31:0] data);
        if ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < src_idle_pct) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= cmd;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        track_decrypt_state(cmd, data);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && m_tready) begin
                if (expected_plain_q.size() == 0) begin
                    report_mismatch("unexpected result", '0, o_m_tdata);
                end else begin
                    logic [31:0] exp_plain;
                    exp_plain = expected_plain_q.pop_front();
                    if (o_m_tdata !== exp_plain)
                        report_mismatch("plain", exp_plain, o_m_tdata);
                end
            end
        end
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    task automatic test_directed_cases();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        send_beat(CMD_LOAD,  32'h0000_0000);
        send_beat(CMD_PLAIN, 32'h0000_0000);
        send_beat(CMD_PLAIN, 32'hFFFF_FFFF);
        send_beat(CMD_WORD,  32'h0000_0000);
        send_beat(CMD_WORD,  32'hFFFF_FFFF);
        send_beat(CMD_BYTE,  32'h0000_0000);
        send_beat(CMD_BYTE,  32'h0000_00FF);
        // upper bits of a byte beat must be ignored
        send_beat(CMD_BYTE,  32'hFFFF_FF00);
        send_beat(CMD_BYTE,  32'hA5C3_3C5A);
        send_beat(CMD_PLAIN, 32'h1234_5678);
        send_beat(CMD_LOAD,  32'hFFFF_FFFF);
        send_beat(CMD_WORD,  32'h0102_0304);
        send_beat(CMD_WORD,  32'h8000_0001);
        send_beat(CMD_PLAIN, 32'hDEAD_BEEF);
        // seed equal to the mask gives an all zero key and table
        send_beat(CMD_LOAD,  SEED_MASK);
        send_beat(CMD_WORD,  32'hCAFE_F00D);
        send_beat(CMD_BYTE,  32'h0000_0080);
        send_beat(CMD_LOAD,  32'hAAAA_AAAA);
        send_beat(CMD_WORD,  32'h7F7F_7F7F);
        send_beat(CMD_BYTE,  32'h0000_007F);
        send_beat(CMD_PLAIN, 32'h8000_0000);
        send_beat(CMD_LOAD,  32'h0000_0000);
        send_beat(CMD_LOAD,  32'h1357_9BDF);
        send_beat(CMD_WORD,  32'hFFFF_0000);
        send_beat(CMD_BYTE,  32'h0000_0001);
    endtask

    task automatic test_random_traffic(input int unsigned n_beats, input int unsigned src_pct,
                                       input int unsigned sink_pct);
        int unsigned pick;
        logic [31:0] data;
        t_cmd        cmd;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        for (int n = 0; n < n_beats; n++) begin
            pick = $urandom_range(99);
            if (pick < 4)       cmd = CMD_LOAD;
            else if (pick < 45) cmd = CMD_WORD;
            else if (pick < 75) cmd = CMD_BYTE;
            else                cmd = CMD_PLAIN;
            pick = $urandom_range(99);
            if (pick < 4)       data = 32'h0000_0000;
            else if (pick < 8)  data = 32'hFFFF_FFFF;
            else if (pick < 12) data = {4{8'($urandom)}};
            else                data = $urandom;
            send_beat(cmd, data);
        end
    endtask

    task automatic finish_run();
        s_tvalid <= 1'b0;
        while (expected_plain_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_plain_q.size() != 0)
            report_mismatch("results left over", '0, expected_plain_q.size());
        if (err_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_cases();
        test_random_traffic(460, 31, 75);
        test_random_traffic(460, 75, 31);
        test_random_traffic(480, 0, 0);
        finish_run();
    end

endmodule
